/* design/bf3_pkg.sv */
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared widths, constants and types of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    // pixel and sum widths
    localparam int PIX_W     = 8;
    localparam int COLSUM_W  = 10;   // sum of three pixels
    localparam int SUM_W     = 12;   // sum of nine pixels

    // configuration and coordinate widths
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 12;
    localparam int OUT_COL_W = 10;
    localparam int ROW_W     = 12;

    // window geometry
    localparam int WIN       = 3;
    localparam int WIN_LAG   = WIN - 1;
    localparam int MIN_DIM   = 3;

    // divide by nine as multiply by ceil(2^16 / 9) and shift, exact for sums up to 2295
    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_W     = 13;
    localparam logic [DIV9_W-1:0] DIV9_MULT = 13'd7282;

    // configuration register map, indexed by paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    // one filtered pixel
    typedef struct packed {
        logic [PIX_W-1:0]     mean;
        logic [OUT_COL_W-1:0] ccol;
        logic [ROW_W-1:0]     crow;
        logic                 last;
    } result_t;

endpackage

/* design/box_filter_3x3_top.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_top
// Streaming 3x3 mean filter over 8-bit gray pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one truncated 3x3 mean per interior
// pixel, tagged with the centre column and row; border pixels give no result
// and frame_last marks the final filtered pixel of a frame. Each pixel does
// one read and one write in each of the two line stores and one shift of the
// three-cell window, so the sustained rate is one pixel per cycle. A
// two-entry result buffer keeps input flowing while a result waits, and input
// stalls only when that buffer is full. Line stores need no clearing after
// reset. Write image_width and image_height only while the block is idle.
// ----------------------------------------------------------------------------
module box_filter_3x3_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel_in,
    // filtered output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  mean_value,
    output logic [9:0]  center_col,
    output logic [11:0] center_row,
    output logic        frame_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bf3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (EW > IMG_W_W) ? EW : IMG_W_W;

    // configuration registers
    logic [IMG_W_W-1:0] img_width_reg;
    logic [IMG_H_W-1:0] img_height_reg;
    logic               cfg_wr;

    // counters
    logic [CW-1:0]      col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [XW-1:0]      w_ext;
    logic [XW-1:0]      w_eff;
    logic [XW-1:0]      col_inc;
    logic [IMG_H_W-1:0] h_eff;
    logic [ROW_W:0]     row_inc;
    logic               col_wrap;
    logic               row_wrap;
    logic               emit0;
    logic               last0;

    // pipeline control
    logic               en;
    logic               accept;
    logic               fifo_full;
    logic               push;

    // stage 1: pixel and line store read
    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_px_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [OUT_COL_W-1:0] s1_ccol_reg;
    logic [ROW_W-1:0]   s1_crow_reg;
    logic [PIX_W-1:0]   top_px;
    logic [PIX_W-1:0]   mid_px;
    logic [COLSUM_W-1:0] colsum_new;
    logic               shift_en;

    // stage 2: window
    logic               s2_emit_reg;
    logic               s2_last_reg;
    logic [OUT_COL_W-1:0] s2_ccol_reg;
    logic [ROW_W-1:0]   s2_crow_reg;
    logic [COLSUM_W-1:0] colsum_chain [WIN+1];
    logic [SUM_W-1:0]   acc_chain [WIN+1];

    // stage 3: window sum and divide
    logic               s3_valid_reg;
    logic [SUM_W-1:0]   s3_sum_reg;
    logic               s3_last_reg;
    logic [OUT_COL_W-1:0] s3_ccol_reg;
    logic [ROW_W-1:0]   s3_crow_reg;
    logic [SUM_W+DIV9_W-1:0] prod;
    result_t            push_data;
    result_t            pop_data;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= IMAGE_WIDTH_RST;
            img_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  img_width_reg  <= pwdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: img_height_reg <= pwdata[IMG_H_W-1:0];
                default:          img_width_reg  <= img_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(img_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(img_height_reg);
            default:          prdata = '0;
        endcase
    end

    // effective frame size
    assign w_ext = XW'(img_width_reg);

    always_comb
    begin
        priority if (w_ext < XW'(MIN_DIM))
        begin
            w_eff = XW'(MIN_DIM);
        end
        else if (w_ext > XW'(MAX_WIDTH))
        begin
            w_eff = XW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
    end

    assign h_eff = (img_height_reg < IMG_H_W'(MIN_DIM)) ? IMG_H_W'(MIN_DIM) : img_height_reg;

    // position of the incoming pixel
    assign col_inc  = XW'(col_reg) + XW'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign col_wrap = (col_inc >= w_eff);
    assign row_wrap = (row_inc >= (ROW_W+1)'(h_eff));
    assign emit0    = (col_reg >= CW'(WIN_LAG)) && (row_reg >= ROW_W'(WIN_LAG));
    assign last0    = (col_inc == w_eff) && (row_inc == (ROW_W+1)'(h_eff));

    // pipeline advances unless the result buffer is full
    assign en       = !fifo_full;
    assign in_ready = en;
    assign accept   = in_valid && in_ready;

    // raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= pixel_in;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= emit0;
            s1_last_reg <= last0;
            s1_ccol_reg <= OUT_COL_W'(col_reg - CW'(1));
            s1_crow_reg <= row_reg - ROW_W'(1);
        end
    end

    bf3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (CW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (shift_en),
        .wr_addr (s1_col_reg),
        .wr_px   (s1_px_reg),
        .top_px  (top_px),
        .mid_px  (mid_px)
    );

    // new window column
    assign shift_en   = en && s1_valid_reg;
    assign colsum_new = COLSUM_W'(top_px) + COLSUM_W'(mid_px) + COLSUM_W'(s1_px_reg);

    // window: chain of column cells, newest at the top index
    assign colsum_chain[WIN] = colsum_new;
    assign acc_chain[WIN]    = '0;

    for (genvar i = 0; i < WIN; i++)
    begin : g_cell
        bf3_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .colsum_in  (colsum_chain[i+1]),
            .acc_in     (acc_chain[i+1]),
            .colsum_out (colsum_chain[i]),
            .acc_out    (acc_chain[i])
        );
    end

    // stage 2 tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_emit_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_emit_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            s2_last_reg <= s1_last_reg;
            s2_ccol_reg <= s1_ccol_reg;
            s2_crow_reg <= s1_crow_reg;
        end
    end

    // stage 3: registered window sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_emit_reg)
        begin
            s3_sum_reg  <= acc_chain[0];
            s3_last_reg <= s2_last_reg;
            s3_ccol_reg <= s2_ccol_reg;
            s3_crow_reg <= s2_crow_reg;
        end
    end

    // divide by nine through reciprocal multiply
    assign prod = (SUM_W+DIV9_W)'(s3_sum_reg) * (SUM_W+DIV9_W)'(DIV9_MULT);

    always_comb
    begin
        push_data.mean = prod[DIV9_SHIFT +: PIX_W];
        push_data.ccol = s3_ccol_reg;
        push_data.crow = s3_crow_reg;
        push_data.last = s3_last_reg;
    end

    assign push = en && s3_valid_reg;

    bf3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop_ready (out_ready),
        .pop_valid (out_valid),
        .pop_data  (pop_data),
        .full      (fifo_full)
    );

    assign mean_value = pop_data.mean;
    assign center_col = pop_data.ccol;
    assign center_row = pop_data.crow;
    assign frame_last = pop_data.last;

`ifndef SYNTH
    // a transfer at the end of a row restarts the column count
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && col_wrap) |=> (col_reg == '0))
        else $error("column counter did not wrap");

    // a stalled pipeline keeps its window sum
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s3_sum_reg) && $stable(s3_valid_reg))
        else $error("pipeline moved during stall");

    // border pixels never produce a result at the sum stage
    a_no_border: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (s3_ccol_reg != '0) && (s3_crow_reg != '0))
        else $error("result for a border pixel");
`endif

endmodule

/* design/bf3_line_buf.sv */
// ----------------------------------------------------------------------------
// bf3_line_buf
// Two line stores holding the previous two rows, registered read port.
// ----------------------------------------------------------------------------
module bf3_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [bf3_pkg::PIX_W-1:0] wr_px,
    output logic [bf3_pkg::PIX_W-1:0] top_px,
    output logic [bf3_pkg::PIX_W-1:0] mid_px
);
    import bf3_pkg::*;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;

    // read both rows at the current column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_rd_reg <= upper_mem[rd_addr];
            mid_rd_reg <= middle_mem[rd_addr];
        end
    end

    // rows move up by one: middle goes to upper, new pixel to middle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= mid_rd_reg;
            middle_mem[wr_addr] <= wr_px;
        end
    end

    assign top_px = top_rd_reg;
    assign mid_px = mid_rd_reg;

endmodule

/* design/bf3_cell.sv */
// ----------------------------------------------------------------------------
// bf3_cell
// One window column: holds the column sum, passes it on and adds it into
// the running window sum.
// ----------------------------------------------------------------------------
module bf3_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [bf3_pkg::COLSUM_W-1:0] colsum_in,
    input  logic [bf3_pkg::SUM_W-1:0]    acc_in,
    output logic [bf3_pkg::COLSUM_W-1:0] colsum_out,
    output logic [bf3_pkg::SUM_W-1:0]    acc_out
);
    import bf3_pkg::*;

    logic [COLSUM_W-1:0] colsum_reg;

    // take the neighbor's column on each shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colsum_reg <= '0;
        end
        else if (shift_en)
        begin
            colsum_reg <= colsum_in;
        end
    end

    assign colsum_out = colsum_reg;
    assign acc_out    = acc_in + SUM_W'(colsum_reg);

endmodule

/* design/bf3_out_fifo.sv */
// ----------------------------------------------------------------------------
// bf3_out_fifo
// Two-entry result buffer that decouples the filter pipeline from the
// output channel.
// ----------------------------------------------------------------------------
module bf3_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bf3_pkg::result_t push_data,
    input  logic             pop_ready,
    output logic             pop_valid,
    output bf3_pkg::result_t pop_data,
    output logic             full
);
    import bf3_pkg::*;

    result_t    ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = ent_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    // occupancy never goes past two
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    // a push never lands on a full buffer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result buffer overflow");
`endif

endmodule
